/* rtl/assert_macros.svh */
// assert_macros.svh: concurrent assertion helpers for the RMS current meter checkers.
// Depends on nothing; included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define CTRMS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define CTRMS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ctrms_pkg.sv */
// ctrms_pkg: widths, reset values, register codes, payload and state types
// of the RMS current meter. No dependencies.
`default_nettype none

package ctrms_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int FRAC_BITS    = 10;
  localparam int CHANNEL_W    = 2;
  localparam int CHANNELS_DEF = 4;

  localparam int OFFSET_W = SAMPLE_BITS + FRAC_BITS + 1;
  localparam int DIFF_W   = OFFSET_W + 1;
  localparam int FILT_W   = DIFF_W - FRAC_BITS;
  localparam int SQ_W     = 2 * FILT_W;
  localparam int SUM_W    = 37;
  localparam int FILL_W   = 13;
  localparam int GAIN_W   = 32;

  localparam int RAD_SHIFT   = 16;
  localparam int ROOT_W      = (SUM_W + RAD_SHIFT + 1) / 2;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int ROOT_REM_W  = ROOT_W + 1;
  localparam int DIV_REM_W   = FILL_W;
  localparam int STEP_W      = $clog2(SUM_W);
  localparam int PROD_W      = GAIN_W + ROOT_W;
  localparam int SCALE_SHIFT = 8;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_CURRENT_GAIN = 1'b1;

  localparam logic [FILL_W-1:0]   SAMPLE_COUNT_RST = 13'd1480;
  localparam logic [GAIN_W-1:0]   CURRENT_GAIN_RST = 32'd1584;
  localparam logic [OFFSET_W-1:0] OFFSET_RST =
    OFFSET_W'(1) << (SAMPLE_BITS - 1 + FRAC_BITS);

  typedef struct packed {
    logic [CHANNEL_W-1:0]   channel;
    logic [SAMPLE_BITS-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0] result_channel;
    logic [GAIN_W-1:0]    rms_current;
  } out_t;

  // One channel's word in the state memory.
  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [SUM_W-1:0]    sum;
    logic [FILL_W-1:0]   fill;
  } entry_t;

  localparam entry_t ENTRY_RST = '{offset: OFFSET_RST, sum: '0, fill: '0};

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [FILL_W-1:0] divisor;
  } root_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } root_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OFFSET,
    ST_ROUND,
    ST_SQUARE,
    ST_WRITE,
    ST_ROOT,
    ST_SCALE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RT_IDLE,
    RT_DIV,
    RT_SQRT,
    RT_DONE
  } root_state_t;

endpackage

`default_nettype wire

/* rtl/ctrms_root_unit.sv */
// ctrms_root_unit: bit-serial floor(sum / fill), then bit-serial isqrt(mean << 16).
// Depends on ctrms_pkg.
`default_nettype none

module ctrms_root_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrms_pkg::root_req_t req,
  output ctrms_pkg::root_rsp_t rsp
);

  ctrms_pkg::root_state_t state_r, state_nxt;

  logic [ctrms_pkg::STEP_W-1:0]     step_r;
  logic [ctrms_pkg::SUM_W-1:0]      quot_r;
  logic [ctrms_pkg::DIV_REM_W-1:0]  drem_r;
  logic [ctrms_pkg::FILL_W-1:0]     divisor_r;
  logic [ctrms_pkg::RAD_W-1:0]      rad_r;
  logic [ctrms_pkg::ROOT_REM_W-1:0] srem_r;
  logic [ctrms_pkg::ROOT_W-1:0]     root_r;

  logic div_last, sqrt_last;
  logic load_div, div_step, load_sqrt, sqrt_step;

  // restoring divide step
  logic [ctrms_pkg::DIV_REM_W:0]   dshift, ddiff;
  logic                            dfit;
  logic [ctrms_pkg::DIV_REM_W-1:0] drem_nxt;
  logic [ctrms_pkg::SUM_W-1:0]     quot_nxt;

  // digit-by-digit root step, two radicand bits per step
  logic [ctrms_pkg::ROOT_REM_W+1:0] sshift, strial, sdiff;
  logic                             sfit;
  logic [ctrms_pkg::ROOT_REM_W-1:0] srem_nxt;
  logic [ctrms_pkg::ROOT_W-1:0]     root_nxt;

  assign div_last  = (step_r == ctrms_pkg::STEP_W'(ctrms_pkg::SUM_W - 1));
  assign sqrt_last = (step_r == ctrms_pkg::STEP_W'(ctrms_pkg::ROOT_W - 1));

  always_comb begin
    dshift   = {drem_r, quot_r[ctrms_pkg::SUM_W-1]};
    ddiff    = dshift - {1'b0, divisor_r};
    dfit     = (dshift >= {1'b0, divisor_r});
    drem_nxt = dfit ? ddiff[ctrms_pkg::DIV_REM_W-1:0] : dshift[ctrms_pkg::DIV_REM_W-1:0];
    quot_nxt = {quot_r[ctrms_pkg::SUM_W-2:0], dfit};
  end

  always_comb begin
    sshift   = {srem_r, rad_r[ctrms_pkg::RAD_W-1 -: 2]};
    strial   = (ctrms_pkg::ROOT_REM_W + 2)'({root_r, 2'b01});
    sdiff    = sshift - strial;
    sfit     = (sshift >= strial);
    srem_nxt = sfit ? sdiff[ctrms_pkg::ROOT_REM_W-1:0] : sshift[ctrms_pkg::ROOT_REM_W-1:0];
    root_nxt = {root_r[ctrms_pkg::ROOT_W-2:0], sfit};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ctrms_pkg::RT_IDLE: if (req.start) state_nxt = ctrms_pkg::RT_DIV;
      ctrms_pkg::RT_DIV:  if (div_last)  state_nxt = ctrms_pkg::RT_SQRT;
      ctrms_pkg::RT_SQRT: if (sqrt_last) state_nxt = ctrms_pkg::RT_DONE;
      ctrms_pkg::RT_DONE: state_nxt = ctrms_pkg::RT_IDLE;
      default:            state_nxt = ctrms_pkg::RT_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    load_div  = (state_r == ctrms_pkg::RT_IDLE) && req.start;
    div_step  = (state_r == ctrms_pkg::RT_DIV);
    load_sqrt = div_step && div_last;
    sqrt_step = (state_r == ctrms_pkg::RT_SQRT);
    rsp.done  = (state_r == ctrms_pkg::RT_DONE);
    rsp.root  = root_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ctrms_pkg::RT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_div) begin
      quot_r    <= req.dividend;
      divisor_r <= req.divisor;
      drem_r    <= '0;
      step_r    <= '0;
    end else if (div_step) begin
      quot_r <= quot_nxt;
      drem_r <= drem_nxt;
      step_r <= div_last ? '0 : step_r + ctrms_pkg::STEP_W'(1);
    end else if (sqrt_step) begin
      step_r <= step_r + ctrms_pkg::STEP_W'(1);
    end

    if (load_sqrt) begin
      rad_r  <= ctrms_pkg::RAD_W'({quot_nxt, {ctrms_pkg::RAD_SHIFT{1'b0}}});
      srem_r <= '0;
      root_r <= '0;
    end else if (sqrt_step) begin
      rad_r  <= rad_r << 2;
      srem_r <= srem_nxt;
      root_r <= root_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/ct_rms_current_meter_core.sv */
// ct_rms_current_meter_core: per-channel DC offset removal, windowed sum of squares
// and RMS current output. Depends on ctrms_pkg and ctrms_root_unit.
//
// Usage:
//  - Input (in_valid / in_stall / in_data): one converter sample with its channel tag
//    per transfer. A sample whose channel is not below CHANNELS is taken and dropped.
//  - Output (out_valid / out_stall / out_data): one transfer per closed window,
//    carrying the channel and its RMS current in unsigned Q16.16.
//  - APB port: sample_count at 0x0 (0 acts as 1), current_gain at 0x4; pready is
//    tied high. Write only while the block is idle.
//  - Per-channel state sits in a small synchronous memory: a read at the transfer,
//    then offset, round, square and accumulate-plus-write-back, each in its own state.
//  - The input stalls until a sample is done: one that closes no window passes the
//    offset, round, square and write states; a closing one then waits for the 37 divide
//    steps and 27 square root steps of the shared bit-serial unit, then scale and emit.
//  - The result sits in an output register; a stalled receiver only holds back the
//    next closing sample, which waits in the emit state until the register frees up.
//  - Reset: every channel reads as offset midscale, empty sum and fill (valid bits
//    cleared by the synchronous reset), registers return to 1480 and 1584.
`default_nettype none

module ct_rms_current_meter_core #(
  parameter int CHANNELS = ctrms_pkg::CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // sample input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ctrms_pkg::in_t                   in_data,
  // result output
  output logic                             out_valid,
  input  logic                             out_stall,
  output ctrms_pkg::out_t                  out_data,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ctrms_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ctrms_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ctrms_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // ---------------------------------------------------------------- config
  logic [ctrms_pkg::FILL_W-1:0]    cfg_count_r;
  logic [ctrms_pkg::GAIN_W-1:0]    cfg_gain_r;
  logic [ctrms_pkg::REG_IDX_W-1:0] reg_idx;
  logic                            cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ctrms_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= ctrms_pkg::SAMPLE_COUNT_RST;
      cfg_gain_r  <= ctrms_pkg::CURRENT_GAIN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ctrms_pkg::REG_SAMPLE_COUNT: cfg_count_r <= pwdata[ctrms_pkg::FILL_W-1:0];
        ctrms_pkg::REG_CURRENT_GAIN: cfg_gain_r  <= pwdata[ctrms_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ctrms_pkg::REG_SAMPLE_COUNT: prdata = ctrms_pkg::CFG_DATA_W'(cfg_count_r);
      ctrms_pkg::REG_CURRENT_GAIN: prdata = ctrms_pkg::CFG_DATA_W'(cfg_gain_r);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- control
  ctrms_pkg::state_t state_r, state_nxt;

  logic in_xfer, in_range, rd_en;
  logic mem_we, off_en, filt_en, sq_en, prod_en, root_start, out_load, out_free;
  logic win_done;

  ctrms_pkg::root_req_t root_req;
  ctrms_pkg::root_rsp_t root_rsp;

  assign in_xfer  = in_valid && !in_stall;
  assign in_range = (32'(in_data.channel) < CHANNELS);
  assign rd_en    = in_xfer && in_range;

  logic                     out_vld_r;
  ctrms_pkg::out_t          out_data_r;

  assign out_free = !out_vld_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ctrms_pkg::ST_IDLE:   if (rd_en) state_nxt = ctrms_pkg::ST_OFFSET;
      ctrms_pkg::ST_OFFSET: state_nxt = ctrms_pkg::ST_ROUND;
      ctrms_pkg::ST_ROUND:  state_nxt = ctrms_pkg::ST_SQUARE;
      ctrms_pkg::ST_SQUARE: state_nxt = ctrms_pkg::ST_WRITE;
      ctrms_pkg::ST_WRITE:  state_nxt = win_done ? ctrms_pkg::ST_ROOT : ctrms_pkg::ST_IDLE;
      ctrms_pkg::ST_ROOT:   if (root_rsp.done) state_nxt = ctrms_pkg::ST_SCALE;
      ctrms_pkg::ST_SCALE:  state_nxt = ctrms_pkg::ST_EMIT;
      ctrms_pkg::ST_EMIT:   if (out_free) state_nxt = ctrms_pkg::ST_IDLE;
      default:              state_nxt = ctrms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state_r != ctrms_pkg::ST_IDLE);
    off_en     = (state_r == ctrms_pkg::ST_OFFSET);
    filt_en    = (state_r == ctrms_pkg::ST_ROUND);
    sq_en      = (state_r == ctrms_pkg::ST_SQUARE);
    mem_we     = (state_r == ctrms_pkg::ST_WRITE);
    root_start = (state_r == ctrms_pkg::ST_WRITE) && win_done;
    prod_en    = (state_r == ctrms_pkg::ST_SCALE);
    out_load   = (state_r == ctrms_pkg::ST_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ctrms_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------- state memory
  ctrms_pkg::entry_t state_mem [CHANNELS];
  ctrms_pkg::entry_t mem_q_r;
  ctrms_pkg::entry_t cur_entry;
  ctrms_pkg::entry_t wr_entry;
  logic [CHANNELS-1:0] vld_r;
  logic                rd_vld_r;
  logic [CH_W-1:0]     rd_idx;

  logic [CH_W-1:0]                  idx_r;
  logic [ctrms_pkg::CHANNEL_W-1:0]  chan_r;
  logic [ctrms_pkg::SAMPLE_BITS-1:0] smp_r;

  assign rd_idx = CH_W'(in_data.channel);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      state_mem[idx_r] <= wr_entry;
    end
    if (rd_en) begin
      mem_q_r  <= state_mem[rd_idx];
      rd_vld_r <= vld_r[rd_idx];
      idx_r    <= rd_idx;
      chan_r   <= in_data.channel;
      smp_r    <= in_data.sample;
    end
  end

  // an entry never written since reset reads as the reset state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[idx_r] <= 1'b1;
    end
  end

  assign cur_entry = rd_vld_r ? mem_q_r : ctrms_pkg::ENTRY_RST;

  // ---------------------------------------------------------------- datapath
  logic signed [ctrms_pkg::DIFF_W-1:0] smp_q, diff, step, diff2, rnd, rnd_sh;
  logic [ctrms_pkg::OFFSET_W-1:0]      off_r;
  logic signed [ctrms_pkg::FILT_W-1:0] filt_r;
  logic signed [ctrms_pkg::SQ_W-1:0]   sq_r;
  logic [ctrms_pkg::SUM_W-1:0]         sum_new;
  logic [ctrms_pkg::FILL_W-1:0]        fill_new, limit;

  // sample in Q.10
  assign smp_q = $signed(ctrms_pkg::DIFF_W'({smp_r, {ctrms_pkg::FRAC_BITS{1'b0}}}));

  // offset += floor((sample - offset) / 1024)
  assign diff = smp_q - $signed({1'b0, cur_entry.offset});
  assign step = diff >>> ctrms_pkg::FRAC_BITS;

  // offset-free sample, rounded half up to an integer
  assign diff2  = smp_q - $signed({1'b0, off_r});
  assign rnd    = diff2 + $signed(ctrms_pkg::DIFF_W'(1 << (ctrms_pkg::FRAC_BITS - 1)));
  assign rnd_sh = rnd >>> ctrms_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (off_en) begin
      off_r <= cur_entry.offset + step[ctrms_pkg::OFFSET_W-1:0];
    end
    if (filt_en) begin
      filt_r <= rnd_sh[ctrms_pkg::FILT_W-1:0];
    end
    if (sq_en) begin
      sq_r <= ctrms_pkg::SQ_W'(filt_r) * ctrms_pkg::SQ_W'(filt_r);
    end
  end

  assign sum_new  = cur_entry.sum + ctrms_pkg::SUM_W'($unsigned(sq_r));
  assign fill_new = cur_entry.fill + ctrms_pkg::FILL_W'(1);
  assign limit    = (cfg_count_r == '0) ? ctrms_pkg::FILL_W'(1) : cfg_count_r;
  assign win_done = (fill_new >= limit);

  always_comb begin
    wr_entry.offset = off_r;
    wr_entry.sum    = win_done ? '0 : sum_new;
    wr_entry.fill   = win_done ? '0 : fill_new;
  end

  // ---------------------------------------------------------------- mean and root
  always_comb begin
    root_req.start    = root_start;
    root_req.dividend = sum_new;
    root_req.divisor  = fill_new;
  end

  ctrms_root_unit u_root (
    .clk (clk),
    .rst_n (rst_n),
    .req (root_req),
    .rsp (root_rsp)
  );

  // ---------------------------------------------------------------- scale and output
  localparam int SCALED_W = ctrms_pkg::PROD_W - ctrms_pkg::SCALE_SHIFT;

  logic [ctrms_pkg::PROD_W-1:0] prod_r;
  logic [SCALED_W-1:0]          scaled;
  logic [ctrms_pkg::GAIN_W-1:0] rms_sat;

  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod_r <= ctrms_pkg::PROD_W'(cfg_gain_r) * ctrms_pkg::PROD_W'(root_rsp.root);
    end
  end

  assign scaled  = prod_r[ctrms_pkg::PROD_W-1:ctrms_pkg::SCALE_SHIFT];
  assign rms_sat = (|scaled[SCALED_W-1:ctrms_pkg::GAIN_W]) ? '1
                                                            : scaled[ctrms_pkg::GAIN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.result_channel <= chan_r;
      out_data_r.rms_current    <= rms_sat;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* rtl/ctrms_checker.sv */
// ctrms_checker: port-level checks of the RMS current meter, bound to the top level.
// Depends on ctrms_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ctrms_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input ctrms_pkg::out_t out_data
);

  // a stalled result stays offered
  `CTRMS_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped under stall")

  // a stalled result keeps its payload
  `CTRMS_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_data), "result payload changed under stall")

  // reset empties the output register
  `CTRMS_ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_valid, "result offered after reset")

  // a result never appears right after a sample transfer
  `CTRMS_ASSERT(a_no_fast_result, clk, rst_n, $rose(out_valid) |-> !$past(in_valid && !in_stall), "result right after sample transfer")

endmodule

bind ct_rms_current_meter_core ctrms_checker u_ctrms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

/* dv/tb_ct_rms_current_meter_core.sv */
// tb_ct_rms_current_meter_core: self-checking bench for the per-channel RMS current meter.
// Drives converter samples and APB register writes, predicts every closed window and
// compares it field by field. Depends on ctrms_pkg and ct_rms_current_meter_core.

module tb_ct_rms_current_meter_core;
  import ctrms_pkg::*;

  // Timing budget. The drain before a register write (and at the end) outlasts a
  // window close inside the core, which leaves comfortable margin.
  localparam int DRAIN_CYCLES   = 120;
  localparam int LONG_HOLD      = 400;   // receiver back-pressure stretch
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer or bus access at all
  localparam int PHASE_ITEMS    = 100;
  localparam int RANDOM_PHASES  = 5;
  localparam int BIG_WINDOW     = 256;   // long window of rail samples
  localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;

  // Register map: one 32-bit word per register.
  localparam logic [CFG_ADDR_W-1:0] ADDR_SAMPLE_COUNT = {REG_SAMPLE_COUNT, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_CURRENT_GAIN = {REG_CURRENT_GAIN, 2'b00};

  // One line of the directed table: either a register write or a sample, and for
  // a few samples an expected result that is obvious by inspection.
  typedef enum logic { ROW_CFG, ROW_SAMPLE } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] wdata;
    in_t                   smp;
    logic                  typed;
    out_t                  want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Shadow of the meter: per-channel offset / sum / fill plus both registers.
  entry_t            chan_state [CHANNELS_DEF];
  logic [FILL_W-1:0] window_len;
  logic [GAIN_W-1:0] gain_q16;

  out_t      pending_rms [$];   // RMS results still owed by the core, oldest first
  stim_row_t directed [$];
  int        fail_count;
  int        quiet_cycles;
  bit        idle_on;           // random gaps / stalls allowed in this phase
  bit        hold_request;      // asks the receiver for one long back-pressure stretch

  ct_rms_current_meter_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Largest r with r*r <= v, found one bit at a time from the top.
  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    int              k;
    r = 0;
    for (k = 31; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic void reset_meter_shadow();
    int c;
    for (c = 0; c < CHANNELS_DEF; c++) chan_state[c] = ENTRY_RST;
    window_len = SAMPLE_COUNT_RST;
    gain_q16   = CURRENT_GAIN_RST;
  endfunction

  // Folds one sample into its channel. Returns 1 and the RMS result when the
  // channel's window closes.
  function automatic bit accumulate_sample(input in_t smp, output out_t res);
    longint            level;
    longint            dev;
    longint            rounded;
    longint unsigned   sq;
    longint unsigned   mean;
    longint unsigned   root;
    longint unsigned   prod;
    logic [FILL_W-1:0] limit;
    entry_t            e;
    e     = chan_state[smp.channel];
    res   = '0;
    level = longint'(smp.sample) << FRAC_BITS;

    // DC tracker: offset moves 1/1024 of the way toward the sample, floor shift.
    dev      = level - longint'(e.offset);
    e.offset = OFFSET_W'(longint'(e.offset) + (dev >>> FRAC_BITS));

    // Offset-free sample, rounded half up to an integer, then squared.
    dev     = level - longint'(e.offset);
    rounded = (dev + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    sq      = rounded * rounded;
    e.sum   = SUM_W'(64'(e.sum) + sq);
    e.fill  = e.fill + FILL_W'(1);

    // A zero window length behaves as one; a shortened window closes at once.
    limit = (window_len == '0) ? FILL_W'(1) : window_len;
    if (e.fill < limit) begin
      chan_state[smp.channel] = e;
      return 1'b0;
    end

    mean = 64'(e.sum) / 64'(e.fill);
    root = isqrt(mean << RAD_SHIFT);
    prod = (64'(gain_q16) * root) >> SCALE_SHIFT;
    if (prod > 64'hFFFF_FFFF) prod = 64'hFFFF_FFFF;

    res.result_channel = smp.channel;
    res.rms_current    = prod[GAIN_W-1:0];
    e.sum  = '0;
    e.fill = '0;
    chan_state[smp.channel] = e;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------

  function automatic stim_row_t cfg_row(input logic [CFG_ADDR_W-1:0] addr,
                                        input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_CFG;
    r.addr  = addr;
    r.wdata = data;
    return r;
  endfunction

  function automatic stim_row_t smp_row(input int ch, input int lvl);
    stim_row_t r;
    r            = '0;
    r.kind       = ROW_SAMPLE;
    r.smp.channel = CHANNEL_W'(ch);
    r.smp.sample  = SAMPLE_BITS'(lvl);
    return r;
  endfunction

  // Sample whose result is known by inspection.
  function automatic stim_row_t known_row(input int ch, input int lvl,
                                          input logic [GAIN_W-1:0] rms);
    stim_row_t r;
    r                     = smp_row(ch, lvl);
    r.typed               = 1'b1;
    r.want.result_channel = CHANNEL_W'(ch);
    r.want.rms_current    = rms;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Bus tasks
  // ---------------------------------------------------------------------------

  // One sample transfer. Data changes only at the falling edge and only after the
  // previous transfer; acceptance is judged on the pre-edge in_stall.
  task automatic send_sample(input in_t smp, input bit typed, input out_t want);
    out_t got;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= smp;
    do @(posedge clk); while (in_stall);
    if (accumulate_sample(smp, got) || typed) pending_rms.push_back(typed ? want : got);
  endtask

  // Stops offering samples and waits until the core has nothing left in flight.
  // Samples that close no window leave nothing in the queue, hence the drain.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rms.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // APB setup + access; data is taken at the edge that ends the access phase.
  task automatic cfg_access(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data,
                            output logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Register write at idle, shadow update, then read back the stored value.
  task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] data);
    logic [CFG_DATA_W-1:0] readback;
    logic [CFG_DATA_W-1:0] held;
    string                 name;
    settle();
    cfg_access(1'b1, addr, data, readback);
    if (addr == ADDR_SAMPLE_COUNT) begin
      window_len = data[FILL_W-1:0];
      held       = CFG_DATA_W'(window_len);
      name       = "sample_count";
    end else begin
      gain_q16 = data;
      held     = data;
      name     = "current_gain";
    end
    cfg_access(1'b0, addr, '0, readback);
    if (readback !== held) begin
      $error("%s: expected %h, actual %h", name, held, readback);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, plus one long hold on request so the core
  // fills its output register and emit stage and has to stall the sample input.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD - 1;
        out_stall    <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every result transfer is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rms.size() == 0) begin
        $error("unexpected result: result_channel %0d rms_current %h",
               out_data.result_channel, out_data.rms_current);
        fail_count++;
      end else begin
        want = pending_rms.pop_front();
        if (out_data.result_channel !== want.result_channel) begin
          $error("result_channel: expected %0d, actual %0d",
                 want.result_channel, out_data.result_channel);
          fail_count++;
        end
        if (out_data.rms_current !== want.rms_current) begin
          $error("rms_current: expected %h, actual %h",
                 want.rms_current, out_data.rms_current);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any transfer or bus access counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t             row;
    in_t                   smp;
    int                    center [CHANNELS_DEF];
    int                    swing [CHANNELS_DEF];
    int                    ph;
    int                    n;
    int                    c;
    int                    lvl;
    logic [FILL_W-1:0]     len;
    logic [CFG_DATA_W-1:0] gain;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    fail_count   = 0;
    quiet_cycles = 0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    reset_meter_shadow();

    // Directed table. Register data carries junk in the unused upper bits of
    // sample_count so every pwdata bit toggles; only the low 13 bits stick.
    // Single-sample windows first: a sample at midscale right after reset sees
    // zero deviation, so its RMS is zero whatever the gain.
    directed.push_back(cfg_row(ADDR_SAMPLE_COUNT, 32'hFFFF_E001));
    directed.push_back(known_row(0, 2048, 32'h0000_0000));
    directed.push_back(smp_row(1, 0));
    directed.push_back(smp_row(2, SAMPLE_MAX));
    directed.push_back(smp_row(3, 12'hAAA));
    // Full-scale gain with a rail sample saturates the product.
    directed.push_back(cfg_row(ADDR_CURRENT_GAIN, 32'hFFFF_FFFF));
    directed.push_back(known_row(1, 0, 32'hFFFF_FFFF));
    directed.push_back(known_row(0, 2048, 32'h0000_0000));
    directed.push_back(smp_row(2, 12'h555));
    // Zero gain forces zero output.
    directed.push_back(cfg_row(ADDR_CURRENT_GAIN, 32'h0000_0000));
    directed.push_back(known_row(3, SAMPLE_MAX, 32'h0000_0000));
    directed.push_back(known_row(1, 12'h555, 32'h0000_0000));
    // Unity gain; a window length of zero behaves as one.
    directed.push_back(cfg_row(ADDR_CURRENT_GAIN, 32'h0001_0000));
    directed.push_back(cfg_row(ADDR_SAMPLE_COUNT, 32'h5555_4000));
    directed.push_back(smp_row(0, SAMPLE_MAX));
    directed.push_back(smp_row(2, 2047));
    // Three-sample window, cut to two while channel 2 already holds two samples:
    // the next sample on that channel closes the window immediately.
    directed.push_back(cfg_row(ADDR_SAMPLE_COUNT, 32'hAAAA_A003));
    directed.push_back(smp_row(2, 100));
    directed.push_back(smp_row(2, 3000));
    directed.push_back(cfg_row(ADDR_SAMPLE_COUNT, 32'h0000_0002));
    directed.push_back(smp_row(2, SAMPLE_MAX));
    directed.push_back(smp_row(3, 1));
    directed.push_back(smp_row(3, 4094));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      row = directed[i];
      if (row.kind == ROW_CFG) begin
        write_register(row.addr, row.wdata);
      end else begin
        send_sample(row.smp, row.typed, row.want);
      end
    end

    // Long window: alternating rails on one channel drive the square sum up;
    // exactly one result at the end of it.
    idle_on = 1'b0;
    write_register(ADDR_SAMPLE_COUNT, CFG_DATA_W'(BIG_WINDOW));
    smp.channel = '0;
    for (n = 0; n < BIG_WINDOW; n++) begin
      smp.sample = n[0] ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
      send_sample(smp, 1'b0, '0);
    end

    // Random phases with short windows so results come often. Most samples are
    // a noisy AC signal around a per-channel DC level, the rest rails and noise.
    // Phase 0 carries the long receiver hold; phase 1 and the last phase run without gaps.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       len = FILL_W'(1);
        1:       len = FILL_W'(4);
        2:       len = FILL_W'(0);
        3:       len = FILL_W'($urandom_range(2, 12));
        default: len = FILL_W'($urandom_range(1, 40));
      endcase
      gain    = (ph == 3) ? CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(0, 32'h0003_0000));
      idle_on = (ph != 1) && (ph != RANDOM_PHASES - 1);
      write_register(ADDR_SAMPLE_COUNT, (CFG_DATA_W'($urandom) & 32'hFFFF_E000) | CFG_DATA_W'(len));
      write_register(ADDR_CURRENT_GAIN, gain);
      for (c = 0; c < CHANNELS_DEF; c++) begin
        center[c] = int'($urandom_range(1500, 2600));
        swing[c]  = int'($urandom_range(0, 2047));
      end
      hold_request = (ph == 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        c = int'($urandom_range(0, CHANNELS_DEF - 1));
        case ($urandom_range(0, 9))
          0:       lvl = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
          1, 2:    lvl = int'($urandom_range(0, SAMPLE_MAX));
          default: lvl = center[c] + int'($urandom_range(0, 2 * swing[c])) - swing[c];
        endcase
        if (lvl < 0) lvl = 0;
        if (lvl > SAMPLE_MAX) lvl = SAMPLE_MAX;
        smp.channel = CHANNEL_W'(c);
        smp.sample  = SAMPLE_BITS'(lvl);
        send_sample(smp, 1'b0, '0);
      end
    end

    // Everything sent: wait out the last results, then give the verdict.
    settle();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
